/* rtl/core/pti_pkg.sv */
// Shared types and constants for the pulse template interpolator.
// No dependencies; imported by the top, pti_front and pti_back.
package pti_pkg;

  // item codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  // how the output stage forms the result
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ZERO  = 2'd0;
  localparam kind_t KIND_DELTA = 2'd1;
  localparam kind_t KIND_TMPL  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_DELTA_MODE = 2'd0;
  localparam logic [1:0] CFG_INV_STEP   = 2'd1;
  localparam logic [1:0] CFG_NUM_POINTS = 2'd2;

  localparam logic [15:0] INV_STEP_RST   = 16'd2560;
  localparam logic [10:0] NUM_POINTS_RST = 11'd1024;

  // tb = time - start spans [-131071, 393215]
  localparam int D_W   = 20;
  // tb * inv_step, Q.16 in sample units
  localparam int POS_W = 35;
  localparam int IDX_W = POS_W - 16;
  // range compare width, holds idx + 2 and any table depth up to 65536
  localparam int CMP_W = IDX_W + 1;

  localparam logic signed [D_W-1:0] DELTA_LO = -20'sd256;
  localparam logic signed [D_W-1:0] DELTA_HI = 20'sd256;

  // load enables of the pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
    logic so;
  } pipe_en_t;

endpackage

/* rtl/core/pulse_template_interpolator.sv */
// Pulse template interpolator: template table lookup with linear interpolation.
// Depends on pti_pkg, pti_table, pti_front and pti_back.
//
// Usage:
//   Input channel (in_valid / in_stall) carries two kinds of item. A write
//   item (in_action = 0) stores in_sample_value at in_sample_index and gives
//   no result. An evaluate item (in_action = 1) gives one out_pulse_value:
//   amplitude times the template interpolated at time_point - start_time,
//   or the rectangular pulse value in delta mode, or zero out of range.
//   Configuration (cfg_we / cfg_index / cfg_wdata) sets delta_mode, inv_step
//   and num_points; write it only while no item is in flight.
//   Throughput: one item per cycle while in_stall is low. The table memory
//   reads both neighbor samples at once; every multiply has its own stage.
//   Path: an evaluate item passes the pipeline stages and the output register
//   before it shows on out_valid. A write reaches the table at the same
//   stage where evaluations read it, so items act in order.
//   Stalls: out_stall holds the output register; the stages behind it keep
//   filling bubbles and in_stall rises only when every stage holds an item.
//   Reset: clears all valid flags and restores the register defaults. The
//   table contents are not cleared; read only entries that were written.
module pulse_template_interpolator
  import pti_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_action,
  input  logic [9:0]          in_sample_index,
  input  logic signed [15:0]  in_sample_value,
  input  logic [17:0]         in_time_point,
  input  logic signed [17:0]  in_start_time,
  input  logic signed [15:0]  in_amplitude,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_pulse_value,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic        delta_mode_r;
  logic [15:0] inv_step_r;
  logic [10:0] num_points_r;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, vo_r;
  pipe_en_t pen;

  logic                is_eval2;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic signed [15:0]  wr_data;
  logic [AW-1:0]       rd_addr0;
  logic [AW-1:0]       rd_addr1;
  logic signed [15:0]  s0;
  logic signed [15:0]  s1;
  logic [15:0]         frac3;
  logic signed [15:0]  amp3;
  kind_t               kind3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_mode_r <= 1'b0;
      inv_step_r   <= INV_STEP_RST;
      num_points_r <= NUM_POINTS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DELTA_MODE: delta_mode_r <= cfg_wdata[0];
        CFG_INV_STEP:   inv_step_r   <= cfg_wdata;
        CFG_NUM_POINTS: num_points_r <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its content moves on
  always_comb begin
    pen.so = !vo_r || !out_stall;
    pen.s6 = !v6_r || pen.so;
    pen.s5 = !v5_r || pen.s6;
    pen.s4 = !v4_r || pen.s5;
    pen.s3 = !v3_r || pen.s4;
    pen.s2 = !v2_r || pen.s3;
    pen.s1 = !v1_r || pen.s2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (pen.s1) v1_r <= in_valid;
      if (pen.s2) v2_r <= v1_r;
      // write items end at the table
      if (pen.s3) v3_r <= v2_r && is_eval2;
      if (pen.s4) v4_r <= v3_r;
      if (pen.s5) v5_r <= v4_r;
      if (pen.s6) v6_r <= v5_r;
      if (pen.so) vo_r <= v6_r;
    end
  end

  pti_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk             (clk),
    .pen             (pen),
    .v2              (v2_r),
    .in_action       (in_action),
    .in_sample_index (in_sample_index),
    .in_sample_value (in_sample_value),
    .in_time_point   (in_time_point),
    .in_start_time   (in_start_time),
    .in_amplitude    (in_amplitude),
    .delta_mode      (delta_mode_r),
    .inv_step        (inv_step_r),
    .num_points      (num_points_r),
    .is_eval2        (is_eval2),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_addr0        (rd_addr0),
    .rd_addr1        (rd_addr1),
    .frac3           (frac3),
    .amp3            (amp3),
    .kind3           (kind3)
  );

  pti_table #(
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (pen.s3),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (s0),
    .rd_data1 (s1)
  );

  pti_back u_back (
    .clk         (clk),
    .pen         (pen),
    .s0          (s0),
    .s1          (s1),
    .frac3       (frac3),
    .amp3        (amp3),
    .kind3       (kind3),
    .pulse_value (out_pulse_value)
  );

  assign in_stall  = !pen.s1;
  assign out_valid = vo_r;

endmodule

/* rtl/core/pti_table.sv */
// Template sample memory: one write port, two registered read ports.
// Depends on nothing but its own parameters.
module pti_table #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic signed [15:0]  wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr0,
  input  logic [AW-1:0]       rd_addr1,
  output logic signed [15:0]  rd_data0,
  output logic signed [15:0]  rd_data1
);

  logic signed [15:0] mem [DEPTH];
  logic signed [15:0] rd0_r;
  logic signed [15:0] rd1_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd0_r <= mem[rd_addr0];
      rd1_r <= mem[rd_addr1];
    end
  end

  assign rd_data0 = rd0_r;
  assign rd_data1 = rd1_r;

endmodule

/* rtl/core/pti_front.sv */
// Front stages: time offset, position multiply, table addressing and writes.
// Depends on pti_pkg.
module pti_front
  import pti_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                clk,
  input  pipe_en_t            pen,
  input  logic                v2,
  input  logic                in_action,
  input  logic [9:0]          in_sample_index,
  input  logic signed [15:0]  in_sample_value,
  input  logic [17:0]         in_time_point,
  input  logic signed [17:0]  in_start_time,
  input  logic signed [15:0]  in_amplitude,
  input  logic                delta_mode,
  input  logic [15:0]         inv_step,
  input  logic [10:0]         num_points,
  output logic                is_eval2,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic signed [15:0]  wr_data,
  output logic [AW-1:0]       rd_addr0,
  output logic [AW-1:0]       rd_addr1,
  output logic [15:0]         frac3,
  output logic signed [15:0]  amp3,
  output kind_t               kind3
);

  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_DEPTH);

  // stage 1
  logic                    act1_r;
  logic [9:0]              widx1_r;
  logic signed [15:0]      wval1_r;
  logic signed [D_W-1:0]   d1_r;
  logic signed [15:0]      amp1_r;
  logic signed [D_W-1:0]   d1_nxt;
  // stage 2
  logic                    act2_r;
  logic [9:0]              widx2_r;
  logic signed [15:0]      wval2_r;
  logic [POS_W-1:0]        pos2_r;
  logic                    dneg2_r;
  logic                    dhit2_r;
  logic signed [15:0]      amp2_r;
  // stage 3 sideband
  logic [15:0]             frac3_r;
  logic signed [15:0]      amp3_r;
  kind_t                   kind3_r;
  kind_t                   kind3_nxt;

  logic [IDX_W-1:0]        idx2;
  logic [IDX_W-1:0]        idx2_p1;
  logic [CMP_W-1:0]        lim;
  logic                    in_rng;
  logic                    widx_ok;

  assign d1_nxt = $signed({2'b00, in_time_point}) - {{2{in_start_time[17]}}, in_start_time};

  always_ff @(posedge clk) begin
    if (pen.s1) begin
      act1_r  <= in_action;
      widx1_r <= in_sample_index;
      wval1_r <= in_sample_value;
      d1_r    <= d1_nxt;
      amp1_r  <= in_amplitude;
    end
  end

  always_ff @(posedge clk) begin
    if (pen.s2) begin
      act2_r  <= act1_r;
      widx2_r <= widx1_r;
      wval2_r <= wval1_r;
      // only used when tb >= 0, so the sign bit is dropped
      pos2_r  <= POS_W'(d1_r[D_W-2:0]) * POS_W'(inv_step);
      dneg2_r <= d1_r[D_W-1];
      dhit2_r <= (d1_r >= DELTA_LO) && (d1_r < DELTA_HI);
      amp2_r  <= amp1_r;
    end
  end

  assign idx2    = pos2_r[POS_W-1:16];
  assign idx2_p1 = idx2 + IDX_W'(1);
  // samples in use, capped at the table size
  assign lim     = ({{(CMP_W-11){1'b0}}, num_points} > DEPTH_C) ? DEPTH_C
                                                                : CMP_W'(num_points);
  assign in_rng  = ({1'b0, idx2} + CMP_W'(2)) <= lim;
  assign widx_ok = 32'(widx2_r) < TABLE_DEPTH;

  always_comb begin
    if (delta_mode) begin
      kind3_nxt = dhit2_r ? KIND_DELTA : KIND_ZERO;
    end else begin
      kind3_nxt = (!dneg2_r && in_rng) ? KIND_TMPL : KIND_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (pen.s3) begin
      frac3_r <= pos2_r[15:0];
      amp3_r  <= amp2_r;
      kind3_r <= kind3_nxt;
    end
  end

  // writes land at the same stage as reads, so item order is kept
  assign is_eval2 = (act2_r == ACT_EVAL);
  assign wr_en    = pen.s3 && v2 && (act2_r == ACT_WRITE) && widx_ok;
  assign wr_addr  = AW'(widx2_r);
  assign wr_data  = wval2_r;
  assign rd_addr0 = AW'(idx2);
  assign rd_addr1 = AW'(idx2_p1);

  assign frac3 = frac3_r;
  assign amp3  = amp3_r;
  assign kind3 = kind3_r;

endmodule

/* rtl/core/pti_back.sv */
// Back stages: interpolation, amplitude scaling, rounding, output register.
// Depends on pti_pkg.
module pti_back
  import pti_pkg::*;
(
  input  logic                clk,
  input  pipe_en_t            pen,
  input  logic signed [15:0]  s0,
  input  logic signed [15:0]  s1,
  input  logic [15:0]         frac3,
  input  logic signed [15:0]  amp3,
  input  kind_t               kind3,
  output logic signed [31:0]  pulse_value
);

  logic signed [16:0] diff;
  logic signed [33:0] prod4_r;
  logic signed [15:0] s0_4_r;
  logic signed [15:0] amp4_r;
  kind_t              kind4_r;
  logic signed [33:0] interp_full;
  logic signed [31:0] interp5_r;
  logic signed [15:0] amp5_r;
  kind_t              kind5_r;
  logic signed [47:0] mp6_r;
  logic signed [15:0] amp6_r;
  kind_t              kind6_r;
  logic signed [47:0] rnd;
  logic signed [31:0] pulse_nxt;
  logic signed [31:0] pulse_r;

  assign diff = {s1[15], s1} - {s0[15], s0};

  always_ff @(posedge clk) begin
    if (pen.s4) begin
      prod4_r <= 34'($signed({1'b0, frac3})) * 34'(diff);
      s0_4_r  <= s0;
      amp4_r  <= amp3;
      kind4_r <= kind3;
    end
  end

  // s0*2^16 + frac*(s1-s0) stays within 32 bits
  assign interp_full = $signed({{2{s0_4_r[15]}}, s0_4_r, 16'h0000}) + prod4_r;

  always_ff @(posedge clk) begin
    if (pen.s5) begin
      interp5_r <= interp_full[31:0];
      amp5_r    <= amp4_r;
      kind5_r   <= kind4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pen.s6) begin
      mp6_r   <= 48'(amp5_r) * 48'(interp5_r);
      amp6_r  <= amp5_r;
      kind6_r <= kind5_r;
    end
  end

  // round half up, then floor shift
  assign rnd = mp6_r + 48'sd32768;

  always_comb begin
    case (kind6_r)
      KIND_TMPL:  pulse_nxt = rnd[47:16];
      KIND_DELTA: pulse_nxt = {amp6_r[15], amp6_r, 15'h0000};
      default:    pulse_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pen.so) begin
      pulse_r <= pulse_nxt;
    end
  end

  assign pulse_value = pulse_r;

endmodule

/* rtl/core/pti_checker.sv */
// Port-level checks for the pulse template interpolator, bound to the top.
// Depends only on the top level's port names.
module pti_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_stall,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_pulse_value
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pulse_value))
    else $error("stalled result changed or dropped");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // input backpressure only when the output is full and held
  a_stall_cause: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output can move");

endmodule

bind pulse_template_interpolator pti_checker u_pti_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_pulse_value (out_pulse_value)
);

/* dv/tb.sv */
`timescale 1ns / 1ps
// Testbench for pulse_template_interpolator: directed table, template load, then random items.
// Depends on pti_pkg and the RTL top; checked against hand values or an in-bench interpolator.
module tb;
  import pti_pkg::*;

  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 12;
  localparam int SEG_ITEMS     = 50;
  localparam int NUM_SEGS      = 6;
  localparam int DEPTH         = 1024;
  localparam int TMPL_LOAD     = 256;

  typedef struct {
    logic               act;
    logic [9:0]         sidx;
    logic signed [15:0] sval;
    logic [17:0]        tp;
    logic signed [17:0] st;
    logic signed [15:0] amp;
  } pulse_item_t;

  typedef struct {
    bit                 is_cfg;
    logic [1:0]         reg_idx;
    logic [15:0]        reg_val;
    pulse_item_t        item;
    bit                 typed;
    logic signed [31:0] want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  wire                in_stall;
  logic               in_action = ACT_WRITE;
  logic [9:0]         in_sample_index = '0;
  logic signed [15:0] in_sample_value = '0;
  logic [17:0]        in_time_point = '0;
  logic signed [17:0] in_start_time = '0;
  logic signed [15:0] in_amplitude = '0;
  wire                out_valid;
  logic               out_stall = 1'b0;
  wire signed [31:0]  out_pulse_value;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_wdata = '0;

  // hand-computed value riding along with a directed item
  logic               row_typed = 1'b0;
  logic signed [31:0] row_want = '0;

  // bench copy of the block state
  logic signed [15:0] tmpl_copy [0:DEPTH-1];
  logic               mode_r = 1'b0;
  logic [15:0]        inv_r = INV_STEP_RST;
  logic [10:0]        npts_r = NUM_POINTS_RST;

  logic signed [31:0] pending_pulses [$];
  logic signed [31:0] head_pulse;
  int                 err_count = 0;
  int                 idle_level = 1;
  bit                 hold_req = 1'b0;

  pulse_template_interpolator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_sample_index (in_sample_index),
    .in_sample_value (in_sample_value),
    .in_time_point   (in_time_point),
    .in_start_time   (in_start_time),
    .in_amplitude    (in_amplitude),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pulse_value (out_pulse_value),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(string msg);
    if (err_count < 100) $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic logic signed [31:0] interp_pulse(logic [17:0] tp, logic signed [17:0] st,
                                                      logic signed [15:0] amp);
    logic signed [20:0] d;
    logic [35:0]        pos;
    int                 idx;
    int                 n_eff;
    longint             s0;
    longint             s1;
    longint             frac;
    longint             acc;
    d = $signed({3'b000, tp}) - $signed({{3{st[17]}}, st});
    interp_pulse = '0;
    if (mode_r) begin
      if (d >= -256 && d < 256) begin
        acc = longint'(amp) * 32768;
        interp_pulse = acc[31:0];
      end
    end else if (!d[20]) begin
      pos = 36'(d[19:0]) * 36'(inv_r);
      idx = int'(pos[35:16]);
      n_eff = (npts_r > DEPTH) ? DEPTH : int'(npts_r);
      if (idx + 2 <= n_eff) begin
        s0 = longint'(tmpl_copy[idx]);
        s1 = longint'(tmpl_copy[idx + 1]);
        frac = longint'(pos[15:0]);
        acc = longint'(amp) * (s0 * 65536 + frac * (s1 - s0)) + 32768;
        acc = acc >>> 16;
        interp_pulse = acc[31:0];
      end
    end
  endfunction

  function automatic pulse_item_t mk_item(logic act, int sidx, int sval, int tp, int st, int amp);
    pulse_item_t it;
    it.act  = act;
    it.sidx = sidx[9:0];
    it.sval = sval[15:0];
    it.tp   = tp[17:0];
    it.st   = st[17:0];
    it.amp  = amp[15:0];
    return it;
  endfunction

  function automatic stim_row_t row_wr(int sidx, int sval);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.item = mk_item(ACT_WRITE, sidx, sval, 0, 0, 0);
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t row_ev(int tp, int st, int amp);
    stim_row_t r;
    r = row_wr(0, 0);
    r.item = mk_item(ACT_EVAL, 0, 0, tp, st, amp);
    return r;
  endfunction

  function automatic stim_row_t row_chk(int tp, int st, int amp, int want);
    stim_row_t r;
    r = row_ev(tp, st, amp);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic stim_row_t row_cfg(logic [1:0] idx, logic [15:0] val);
    stim_row_t r;
    r = row_wr(0, 0);
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(0, 15))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic bit take_break();
    case (idle_level)
      1: return $urandom_range(0, 15) == 0;
      2: return $urandom_range(0, 3) == 0;
      default: return 1'b0;
    endcase
  endfunction

  // Mostly evaluations whose tb lands on the used part of the table, with
  // some writes, some negative tb, some past the end and some raw noise.
  function automatic pulse_item_t rand_item();
    pulse_item_t it;
    int sel;
    int d;
    int span;
    int n_eff;
    int lo;
    int hi;
    int st;
    it = mk_item(ACT_EVAL, $urandom, rand_sample(), $urandom, $urandom, $urandom);
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      it.act = ACT_WRITE;
      return it;
    end
    if (sel < 35) return it;
    n_eff = (npts_r > DEPTH) ? DEPTH : int'(npts_r);
    if (mode_r) begin
      d = int'($urandom_range(0, 640)) - 320;
    end else if (sel < 42) begin
      d = -int'($urandom_range(1, 131071));
    end else begin
      span = (inv_r == 0 || n_eff < 2) ? 4096 : ((n_eff - 1) * 65536) / int'(inv_r);
      span = span + span / 16 + 1;
      if (span > 393215) span = 393215;
      d = $urandom_range(0, span);
    end
    lo = (-d > -131072) ? -d : -131072;
    hi = (262143 - d < 131071) ? 262143 - d : 131071;
    st = lo + int'($urandom_range(0, hi - lo));
    lo = st + d;
    it.st = st[17:0];
    it.tp = lo[17:0];
    return it;
  endfunction

  task automatic send_item(pulse_item_t it, bit typed, logic signed [31:0] want);
    if (take_break()) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= it.act;
    in_sample_index <= it.sidx;
    in_sample_value <= it.sval;
    in_time_point   <= it.tp;
    in_start_time   <= it.st;
    in_amplitude    <= it.amp;
    row_typed       <= typed;
    row_want        <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Wait until the pipe is empty; writes give no result, so pad by the latency.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DELTA_MODE: mode_r = val[0];
      CFG_INV_STEP:   inv_r = val;
      CFG_NUM_POINTS: npts_r = val[10:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pulses.size() == 0) begin
        flag_error($sformatf("result %0d with no item pending", out_pulse_value));
      end else begin
        head_pulse = pending_pulses.pop_front();
        if (out_pulse_value !== head_pulse)
          flag_error($sformatf("pulse_value %0d, predicted %0d", out_pulse_value, head_pulse));
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      if (in_action == ACT_WRITE)
        tmpl_copy[in_sample_index] = in_sample_value;
      else if (row_typed)
        pending_pulses.push_back(row_want);
      else
        pending_pulses.push_back(interp_pulse(in_time_point, in_start_time, in_amplitude));
    end
  end

  // receiver: random stall bursts, plus one long hold-off to back up the pipe
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (take_break()) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  initial begin
    stim_row_t dir_tab [$];
    int seg;
    int waited;
    // template mode at reset values: extremes, negative tb, past the end
    dir_tab.push_back(row_wr(0, 32767));
    dir_tab.push_back(row_wr(1, -32768));
    dir_tab.push_back(row_wr(1022, -1));
    dir_tab.push_back(row_wr(1023, 12345));
    dir_tab.push_back(row_chk(0, 0, 32767, 1073676289));
    dir_tab.push_back(row_chk(0, 0, -32768, -1073709056));
    dir_tab.push_back(row_chk(5, 5, -1, -32767));
    dir_tab.push_back(row_chk(0, 1, 1000, 0));
    dir_tab.push_back(row_chk(262143, -131072, -32768, 0));
    dir_tab.push_back(row_ev(13, 0, 32767));
    dir_tab.push_back(row_chk(131071, 131071, 0, 0));
    // delta mode, window edges; upper config bits are don't-care
    dir_tab.push_back(row_cfg(CFG_DELTA_MODE, 16'hFFFF));
    dir_tab.push_back(row_chk(1000, 1000, -32768, -1073741824));
    dir_tab.push_back(row_chk(255, 0, 32767, 1073709056));
    dir_tab.push_back(row_chk(0, 256, 5, 163840));
    dir_tab.push_back(row_chk(256, 0, 5, 0));
    dir_tab.push_back(row_chk(0, 257, 5, 0));
    // sample count above the table depth clamps to the depth
    dir_tab.push_back(row_cfg(CFG_DELTA_MODE, 16'hFFFE));
    dir_tab.push_back(row_cfg(CFG_INV_STEP, 16'd256));
    dir_tab.push_back(row_cfg(CFG_NUM_POINTS, 16'hFFFF));
    dir_tab.push_back(row_ev(261760, 0, 32767));
    dir_tab.push_back(row_chk(261888, 0, 7, 0));
    // fewer than two samples in use
    dir_tab.push_back(row_cfg(CFG_NUM_POINTS, 16'd1));
    dir_tab.push_back(row_chk(0, 0, 7, 0));
    dir_tab.push_back(row_cfg(CFG_NUM_POINTS, 16'd0));
    dir_tab.push_back(row_chk(100, 0, 7, 0));
    // zero reciprocal step pins every tb >= 0 to sample 0
    dir_tab.push_back(row_cfg(CFG_NUM_POINTS, 16'd1024));
    dir_tab.push_back(row_cfg(CFG_INV_STEP, 16'd0));
    dir_tab.push_back(row_chk(262143, 0, 2, 65534));
    dir_tab.push_back(row_chk(0, -131072, -3, -98301));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        settle();
        cfg_write(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // load the low part of the template; later sample counts stay within it
    for (int i = 0; i < TMPL_LOAD; i++)
      send_item(mk_item(ACT_WRITE, i, rand_sample(), $urandom, $urandom, $urandom), 1'b0, '0);

    for (seg = 0; seg < NUM_SEGS; seg++) begin
      settle();
      case (seg)
        0: begin
          cfg_write(CFG_DELTA_MODE, 16'h0000);
          cfg_write(CFG_INV_STEP, INV_STEP_RST);
          cfg_write(CFG_NUM_POINTS, 16'(TMPL_LOAD));
        end
        1: begin
          cfg_write(CFG_DELTA_MODE, 16'h0000);
          cfg_write(CFG_INV_STEP, 16'd256);
          cfg_write(CFG_NUM_POINTS, 16'd20);
        end
        2: begin
          cfg_write(CFG_DELTA_MODE, 16'h0000);
          cfg_write(CFG_INV_STEP, 16'd65535);
          cfg_write(CFG_NUM_POINTS, 16'(TMPL_LOAD));
        end
        3: begin
          cfg_write(CFG_DELTA_MODE, 16'($urandom | 1));
          cfg_write(CFG_INV_STEP, 16'($urandom_range(256, 65535)));
          cfg_write(CFG_NUM_POINTS, 16'($urandom_range(20, TMPL_LOAD)));
        end
        4: begin
          cfg_write(CFG_DELTA_MODE, 16'($urandom & 16'hFFFE));
          cfg_write(CFG_INV_STEP, 16'($urandom_range(256, 65535)));
          cfg_write(CFG_NUM_POINTS,
                    16'($urandom_range(20, TMPL_LOAD) | ($urandom_range(0, 31) << 11)));
        end
        default: begin
          cfg_write(CFG_DELTA_MODE, 16'h0000);
          cfg_write(CFG_INV_STEP, 16'($urandom_range(256, 65535)));
          cfg_write(CFG_NUM_POINTS, 16'(TMPL_LOAD));
        end
      endcase
      for (int i = 0; i < SEG_ITEMS; i++) begin
        if (seg == NUM_SEGS - 1) idle_level = 0;
        else if (i % 25 == 0) idle_level = $urandom_range(0, 2);
        if (seg == 2 && i == 40) begin
          idle_level = 0;
          hold_req = 1'b1;
        end
        send_item(rand_item(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    for (waited = 0; waited < 20000 && pending_pulses.size() != 0; waited++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_pulses.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_pulses.size()));
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
